// File: hdl/rpv_pkg.sv
package rpv_pkg;

  localparam int SIDE_BITS  = 11;
  localparam int FRAC_BITS  = 12;
  localparam int COORD_BITS = 12 + FRAC_BITS;
  localparam int RAD_BITS   = COORD_BITS - 1;
  localparam int ROT_BITS   = 16;

  localparam int MAX_SIDES_DEF = 1024;

  // angle units: 1/64 degree
  localparam int TURN    = 23040;
  localparam int QUARTER = 5760;

  // round(k * TURN / n): numerator k*TURN + n/2, quotient never above TURN
  localparam int NUM_BITS = 25;
  localparam int QUO_BITS = 15;
  localparam int T_BITS   = 15;
  localparam int REM_BITS = 13;

  // CORDIC: x/y in Q30, z in 2^-22 degree
  localparam int CORDIC_STEPS = 20;
  localparam int XW           = 32;
  localparam int ZW           = 31;
  localparam int TRIG_W       = 27;
  localparam int PROD_W       = RAD_BITS + 1 + TRIG_W;
  localparam int SUM_W        = TRIG_W + 1;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic [27:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
    28'd188743680, 28'd111421900, 28'd58872272, 28'd29884485, 28'd15000234,
    28'd7507429,   28'd3754631,   28'd1877430,  28'd938729,   28'd469367,
    28'd234683,    28'd117342,    28'd58671,    28'd29335,    28'd14668,
    28'd7334,      28'd3667,      28'd1833,     28'd917,      28'd458
  };

  typedef struct packed {
    logic                          ok;
    logic [RAD_BITS-1:0]           r;
    logic signed [COORD_BITS-1:0]  cx;
    logic signed [COORD_BITS-1:0]  cy;
  } side_t;

  typedef struct packed {
    logic                        vld;
    logic [NUM_BITS-1:0]         rem;
    logic [QUO_BITS-1:0]         quo;
    logic [SIDE_BITS-1:0]        dvs;
    logic signed [ROT_BITS-1:0]  rot;
    side_t                       side;
  } div_t;

  typedef struct packed {
    logic                  vld;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [ZW-1:0]  z;
    logic [1:0]            quad;
    side_t                 side;
  } cord_t;

endpackage

// File: hdl/rpv_div_cell.sv
module rpv_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  rpv_pkg::div_t din,
  output rpv_pkg::div_t dout
);
  import rpv_pkg::*;

  logic [NUM_BITS:0]   dsh;
  logic [NUM_BITS:0]   diff;
  logic [QUO_BITS-1:0] quo_set;

  assign dsh  = (NUM_BITS + 1)'(din.dvs) << SHIFT;
  assign diff = {1'b0, din.rem} - dsh;

  always_comb begin
    quo_set = din.quo;
    quo_set[SHIFT] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.dvs  <= din.dvs;
    dout.rot  <= din.rot;
    dout.side <= din.side;
    if (!diff[NUM_BITS]) begin
      dout.rem <= diff[NUM_BITS-1:0];
      dout.quo <= quo_set;
    end else begin
      dout.rem <= din.rem;
      dout.quo <= din.quo;
    end
  end

endmodule

// File: hdl/rpv_cordic_cell.sv
module rpv_cordic_cell #(
  parameter int ITER = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  rpv_pkg::cord_t din,
  output rpv_pkg::cord_t dout
);
  import rpv_pkg::*;

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] az;

  assign xs = din.x >>> ITER;
  assign ys = din.y >>> ITER;
  assign az = $signed(ZW'(ATAN_TAB[ITER]));

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.quad <= din.quad;
    dout.side <= din.side;
    // rotate toward z = 0
    if (!din.z[ZW-1]) begin
      dout.x <= din.x - ys;
      dout.y <= din.y + xs;
      dout.z <= din.z - az;
    end else begin
      dout.x <= din.x + ys;
      dout.y <= din.y - xs;
      dout.z <= din.z + az;
    end
  end

endmodule

// File: hdl/regular_polygon_vertex.sv
// Throughput: one request per clock; busy stays low.
// Depth is 15 divider cells (one per quotient bit of the angle step), 20 CORDIC
// cells (one per iteration) and 6 stages of angle reduction, rounding and scaling.
// Reset clears only the pipeline valid bits; the receiver cannot stall done.
module regular_polygon_vertex #(
  parameter int MAX_SIDES = rpv_pkg::MAX_SIDES_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [rpv_pkg::SIDE_BITS-1:0]           sides,
  input  logic [rpv_pkg::SIDE_BITS-1:0]           vertex_index,
  input  logic signed [rpv_pkg::COORD_BITS-1:0]   center_x,
  input  logic signed [rpv_pkg::COORD_BITS-1:0]   center_y,
  input  logic [rpv_pkg::RAD_BITS-1:0]            circ_radius,
  input  logic signed [rpv_pkg::ROT_BITS-1:0]     rotation,
  output logic                                    done,
  output logic signed [rpv_pkg::COORD_BITS-1:0]   vertex_x,
  output logic signed [rpv_pkg::COORD_BITS-1:0]   vertex_y,
  output logic                                    valid_res
);
  import rpv_pkg::*;

  div_t  fr;
  div_t  dch [0:QUO_BITS];
  cord_t cfr;
  cord_t cch [0:CORDIC_STEPS];

  logic ok_in;

  // angle reduction stage
  logic                       a_vld;
  logic [T_BITS-1:0]          a_t;
  side_t                      a_side;
  logic signed [17:0]         tsum;
  logic [16:0]                tu;
  logic [16:0]                t_next;

  // quadrant split
  logic [1:0]                 q_next;
  logic [T_BITS-1:0]          qr_next;

  // trig stage
  logic                       c_vld;
  logic signed [TRIG_W-1:0]   c_cos;
  logic signed [TRIG_W-1:0]   c_sin;
  side_t                      c_side;
  logic signed [XW:0]         xr;
  logic signed [XW:0]         yr;
  logic signed [TRIG_W-1:0]   cq;
  logic signed [TRIG_W-1:0]   sq;
  logic signed [TRIG_W-1:0]   cos_next;
  logic signed [TRIG_W-1:0]   sin_next;

  // scale stage
  logic                       m_vld;
  logic signed [PROD_W-1:0]   m_px;
  logic signed [PROD_W-1:0]   m_py;
  side_t                      m_side;

  // offset and saturate
  logic signed [PROD_W-1:0]   px_rnd;
  logic signed [PROD_W-1:0]   py_rnd;
  logic signed [SUM_W-1:0]    vx_sum;
  logic signed [SUM_W-1:0]    vy_sum;
  logic signed [COORD_BITS-1:0] vx_sat;
  logic signed [COORD_BITS-1:0] vy_sat;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(1 <<< (COORD_BITS - 1));

  assign busy = 1'b0;

  assign ok_in = (sides >= SIDE_BITS'(3)) && (32'(sides) <= MAX_SIDES) &&
                 (vertex_index <= sides);

  // front register: numerator of the rounded angle step
  always_ff @(posedge clk) begin
    if (rst) begin
      fr.vld <= 1'b0;
    end else begin
      fr.vld <= start && !busy;
    end
    fr.rem     <= NUM_BITS'(vertex_index) * NUM_BITS'(TURN) + NUM_BITS'(sides >> 1);
    fr.quo     <= '0;
    fr.dvs     <= sides;
    fr.rot     <= rotation;
    fr.side.ok <= ok_in;
    fr.side.r  <= circ_radius;
    fr.side.cx <= center_x;
    fr.side.cy <= center_y;
  end

  assign dch[0] = fr;

  for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
    rpv_div_cell #(.SHIFT(QUO_BITS - 1 - g)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (dch[g]),
      .dout (dch[g+1])
    );
  end

  // rotation + step, wrapped into one turn
  always_comb begin
    tsum = 18'(dch[QUO_BITS].rot) + 18'(dch[QUO_BITS].quo) + 18'(2 * TURN);
    tu   = tsum[16:0];
    priority if (tu >= 17'(4 * TURN)) begin
      t_next = tu - 17'(4 * TURN);
    end else if (tu >= 17'(3 * TURN)) begin
      t_next = tu - 17'(3 * TURN);
    end else if (tu >= 17'(2 * TURN)) begin
      t_next = tu - 17'(2 * TURN);
    end else if (tu >= 17'(TURN)) begin
      t_next = tu - 17'(TURN);
    end else begin
      t_next = tu;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= dch[QUO_BITS].vld;
    end
    a_t    <= t_next[T_BITS-1:0];
    a_side <= dch[QUO_BITS].side;
  end

  always_comb begin
    priority if (a_t >= T_BITS'(3 * QUARTER)) begin
      q_next  = 2'd3;
      qr_next = a_t - T_BITS'(3 * QUARTER);
    end else if (a_t >= T_BITS'(2 * QUARTER)) begin
      q_next  = 2'd2;
      qr_next = a_t - T_BITS'(2 * QUARTER);
    end else if (a_t >= T_BITS'(QUARTER)) begin
      q_next  = 2'd1;
      qr_next = a_t - T_BITS'(QUARTER);
    end else begin
      q_next  = 2'd0;
      qr_next = a_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfr.vld <= 1'b0;
    end else begin
      cfr.vld <= a_vld;
    end
    cfr.x    <= CORDIC_GAIN;
    cfr.y    <= '0;
    cfr.z    <= $signed(ZW'({qr_next[REM_BITS-1:0], 16'b0}));
    cfr.quad <= q_next;
    cfr.side <= a_side;
  end

  assign cch[0] = cfr;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    rpv_cordic_cell #(.ITER(i)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (cch[i]),
      .dout (cch[i+1])
    );
  end

  // Q30 -> Q24 with rounding, then unfold the quadrant
  always_comb begin
    xr = (XW + 1)'(cch[CORDIC_STEPS].x) + (XW + 1)'(32);
    yr = (XW + 1)'(cch[CORDIC_STEPS].y) + (XW + 1)'(32);
    cq = xr[XW:6];
    sq = yr[XW:6];
    unique case (cch[CORDIC_STEPS].quad)
      2'd0: begin
        cos_next = cq;
        sin_next = sq;
      end
      2'd1: begin
        cos_next = -sq;
        sin_next = cq;
      end
      2'd2: begin
        cos_next = -cq;
        sin_next = -sq;
      end
      default: begin
        cos_next = sq;
        sin_next = -cq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= cch[CORDIC_STEPS].vld;
    end
    c_cos  <= cos_next;
    c_sin  <= sin_next;
    c_side <= cch[CORDIC_STEPS].side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= c_vld;
    end
    m_px   <= $signed({1'b0, c_side.r}) * c_cos;
    m_py   <= $signed({1'b0, c_side.r}) * c_sin;
    m_side <= c_side;
  end

  always_comb begin
    px_rnd = m_px + (PROD_W'(1) <<< 23);
    py_rnd = m_py + (PROD_W'(1) <<< 23);
    vx_sum = SUM_W'($signed(px_rnd[PROD_W-1:24])) + SUM_W'(m_side.cx);
    vy_sum = SUM_W'($signed(py_rnd[PROD_W-1:24])) + SUM_W'(m_side.cy);
    priority if (vx_sum > SAT_HI) begin
      vx_sat = SAT_HI[COORD_BITS-1:0];
    end else if (vx_sum < SAT_LO) begin
      vx_sat = SAT_LO[COORD_BITS-1:0];
    end else begin
      vx_sat = vx_sum[COORD_BITS-1:0];
    end
    priority if (vy_sum > SAT_HI) begin
      vy_sat = SAT_HI[COORD_BITS-1:0];
    end else if (vy_sum < SAT_LO) begin
      vy_sat = SAT_LO[COORD_BITS-1:0];
    end else begin
      vy_sat = vy_sum[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_vld;
    end
    valid_res <= m_side.ok;
    vertex_x  <= m_side.ok ? vx_sat : '0;
    vertex_y  <= m_side.ok ? vy_sat : '0;
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rpv_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 550;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         ok;
  } vertex_t;

  class vertex_scoreboard;
    vertex_t pending_vertices[$];
    int      errors = 0;

    function void report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endfunction

    function int outstanding();
      return pending_vertices.size();
    endfunction

    // Predicts the vertex for one accepted request and queues it.
    function void note_request(logic [SIDE_BITS-1:0] n_sides, logic [SIDE_BITS-1:0] idx,
                               logic signed [COORD_BITS-1:0] cx,
                               logic signed [COORD_BITS-1:0] cy,
                               logic [RAD_BITS-1:0] rad, logic signed [ROT_BITS-1:0] rot);
      longint  n, k, ro, r, ang_step, t, x, y, z, nx, ang, cq, sq, cs, sn, vx, vy;
      longint  hi, lo;
      int      quad;
      vertex_t v;
      n  = n_sides;
      k  = idx;
      ro = rot;
      r  = rad;
      hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
      lo = -(64'sd1 <<< (COORD_BITS - 1));
      if (n < 3 || n > MAX_SIDES_DEF || k > n) begin
        v.x = '0;
        v.y = '0;
        v.ok = 1'b0;
      end else begin
        ang_step = (k * TURN + n / 2) / n;
        t = (ro + ang_step) % TURN;
        if (t < 0) t += TURN;
        quad = int'(t / QUARTER);
        // reduced angle in 2^-22 degree units
        z = (t % QUARTER) * 65536;
        x = CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
          ang = ATAN_TAB[i];
          if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - ang;
          end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + ang;
          end
          x = nx;
        end
        cq = (x + 32) >>> 6;
        sq = (y + 32) >>> 6;
        case (quad)
          0: begin cs = cq;  sn = sq;  end
          1: begin cs = -sq; sn = cq;  end
          2: begin cs = -cq; sn = -sq; end
          default: begin cs = sq; sn = -cq; end
        endcase
        vx = longint'(cx) + ((r * cs + (64'sd1 <<< 23)) >>> 24);
        vy = longint'(cy) + ((r * sn + (64'sd1 <<< 23)) >>> 24);
        if (vx > hi) vx = hi;
        if (vx < lo) vx = lo;
        if (vy > hi) vy = hi;
        if (vy < lo) vy = lo;
        v.x = vx[COORD_BITS-1:0];
        v.y = vy[COORD_BITS-1:0];
        v.ok = 1'b1;
      end
      pending_vertices.push_back(v);
    endfunction

    function void check_vertex(logic signed [COORD_BITS-1:0] x,
                               logic signed [COORD_BITS-1:0] y, logic ok);
      vertex_t want;
      if (pending_vertices.size() == 0) begin
        report($sformatf("vertex with none pending: x=%0d y=%0d valid=%0b", x, y, ok));
        return;
      end
      want = pending_vertices.pop_front();
      if (ok !== want.ok)
        report($sformatf("valid_res got %0b expected %0b", ok, want.ok));
      if (x !== want.x)
        report($sformatf("vertex_x got %0d expected %0d", x, want.x));
      if (y !== want.y)
        report($sformatf("vertex_y got %0d expected %0d", y, want.y));
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [SIDE_BITS-1:0] sides = '0;
  logic [SIDE_BITS-1:0] vertex_index = '0;
  logic signed [COORD_BITS-1:0] center_x = '0;
  logic signed [COORD_BITS-1:0] center_y = '0;
  logic [RAD_BITS-1:0] circ_radius = '0;
  logic signed [ROT_BITS-1:0] rotation = '0;
  logic done;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic valid_res;

  vertex_scoreboard board = new();
  int cycle_count = 0;
  bit burst = 1'b0;

  regular_polygon_vertex u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sides        (sides),
    .vertex_index (vertex_index),
    .center_x     (center_x),
    .center_y     (center_y),
    .circ_radius  (circ_radius),
    .rotation     (rotation),
    .done         (done),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .valid_res    (valid_res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // done is a one-cycle strobe; the beat is taken at the edge ending it
  always @(posedge clk) begin
    if (!rst && done) board.check_vertex(vertex_x, vertex_y, valid_res);
  end

  // a beat is taken when start is high and busy is low; start stays up across
  // back-to-back beats
  task automatic send_request(input logic [SIDE_BITS-1:0] n, input logic [SIDE_BITS-1:0] k,
                              input logic signed [COORD_BITS-1:0] cx,
                              input logic signed [COORD_BITS-1:0] cy,
                              input logic [RAD_BITS-1:0] rad,
                              input logic signed [ROT_BITS-1:0] rot);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    sides        <= n;
    vertex_index <= k;
    center_x     <= cx;
    center_y     <= cy;
    circ_radius  <= rad;
    rotation     <= rot;
    do @(posedge clk); while (busy);
    board.note_request(n, k, cx, cy, rad, rot);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [RAD_BITS-1:0] RMAX = '1;

  initial begin
    logic [SIDE_BITS-1:0]         n, k;
    logic signed [COORD_BITS-1:0] cx, cy;
    logic [RAD_BITS-1:0]          rad;
    logic signed [ROT_BITS-1:0]   rot;
    int                           pick;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // outline corners, invalid counts, rotation extremes, saturation
    send_request(3, 0, 0, 0, 4096, 0);
    send_request(3, 3, 0, 0, 4096, 0);
    send_request(0, 0, 100, -100, 4096, 0);
    send_request(1, 0, 0, 0, 4096, 0);
    send_request(2, 1, 0, 0, 4096, 0);
    send_request(1024, 1023, CMAX, CMIN, RMAX, 23040);
    send_request(1025, 0, 0, 0, 4096, 0);
    send_request(2047, 2047, -1, -1, RMAX, -1);
    send_request(2047, 0, 0, 0, 4096, 0);
    send_request(4, 5, 0, 0, 4096, 0);
    send_request(6, 2, 4096, -4096, 40960, -23040);
    send_request(8, 3, 0, 0, 81920, 16'sh8000);
    send_request(5, 1, 0, 0, 81920, 16'sh7fff);
    send_request(4, 0, CMAX, CMAX, RMAX, 0);
    send_request(4, 2, CMIN, CMIN, RMAX, 0);
    send_request(4, 1, CMAX, CMIN, RMAX, 0);
    send_request(1024, 512, CMIN, CMAX, 0, 100);
    send_request(7, 7, -1, -1, RMAX, -1);
    send_request(12, 11, -1, -1, RMAX, 5760);
    send_request(3, 2, 0, 0, 8192, 1);
    send_request(1000, 999, 0, 0, RMAX, -5760);
    send_request(360, 90, 0, 0, RMAX, 11520);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      burst = ((i / 40) % 3) == 1;
      if (i == RANDOM_ITEMS / 2) drain();
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        n   = SIDE_BITS'($urandom);
        k   = SIDE_BITS'($urandom);
        cx  = COORD_BITS'($urandom);
        cy  = COORD_BITS'($urandom);
        rad = RAD_BITS'($urandom);
        rot = ROT_BITS'($urandom);
      end else begin
        n = ($urandom_range(0, 2) == 0) ? SIDE_BITS'($urandom_range(3, 16)) :
                                          SIDE_BITS'($urandom_range(3, 1024));
        k = SIDE_BITS'($urandom_range(0, int'(n)));
        rot = ($urandom_range(0, 4) == 0) ? ROT_BITS'($urandom) :
                                            ROT_BITS'(int'($urandom_range(0, 46080)) - 23040);
        if ($urandom_range(0, 1) == 0) begin
          cx = COORD_BITS'($urandom);
          cy = COORD_BITS'($urandom);
        end else begin
          cx = COORD_BITS'(int'($urandom_range(0, 2097152)) - 1048576);
          cy = COORD_BITS'(int'($urandom_range(0, 2097152)) - 1048576);
        end
        rad = ($urandom_range(0, 1) == 0) ? RAD_BITS'($urandom) :
                                            RAD_BITS'($urandom_range(0, 1048576));
      end
      send_request(n, k, cx, cy, rad, rot);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: regular_polygon_vertex.f
hdl/rpv_pkg.sv
hdl/rpv_div_cell.sv
hdl/rpv_cordic_cell.sv
hdl/regular_polygon_vertex.sv
test/testbench.sv
